// ===== rtl/fsrl_pkg.sv =====
// shared types and constants for the flap schedule rate limiter
// packing of the stream items, fixed-point limits, reciprocal constants
// used by fsrl_sched, fsrl_lane and flap_schedule_rate_limiter
package fsrl_pkg;

    // item widths
    localparam int IN_W    = 112;
    localparam int OUT_W   = 64;
    localparam int FRAC_W  = 16;
    localparam int TARG_W  = 17;
    localparam int LANES   = 4;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 2'd1;

    localparam logic [FRAC_W-1:0] STEP_RESET = 16'd655;
    localparam logic [FRAC_W-1:0] TOL_RESET  = 16'd328;

    // flap lever codes
    localparam logic [1:0] LEVER_AUTO = 2'd0;
    localparam logic [1:0] LEVER_HALF = 2'd1;
    localparam logic [1:0] LEVER_FULL = 2'd2;

    // target fractions, full travel = 65536
    localparam logic [TARG_W-1:0] FULL_FRAC   = 17'd65536;
    localparam logic [TARG_W-1:0] LEF_GROUND  = 17'd23831;
    localparam logic [TARG_W-1:0] TEF_30      = 17'd43691;
    localparam logic [TARG_W-1:0] TEF_8       = 17'd11651;
    localparam logic [TARG_W-1:0] TEF_PLATEAU = 17'd24030;

    // mach thresholds in Q2.10, inclusive upper bounds of each band
    localparam logic [11:0] MACH_LEF_MAX  = 12'd778;   // below 0.76
    localparam logic [11:0] MACH_AOA_MAX  = 12'd921;   // below 0.9
    localparam logic [11:0] MACH_CLIP_MAX = 12'd1075;  // below 1.05

    // aoa breakpoints in 1/256 degree
    localparam logic signed [15:0] AOA_RISE_END = 16'sd2816;
    localparam logic signed [15:0] AOA_PLAT_END = 16'sd4096;
    localparam logic signed [15:0] AOA_FALL_END = 16'sd6400;

    // airspeed law applies below 250 kn
    localparam logic [13:0] SPEED_LAW_MAX = 14'd4000;

    // exact reciprocals: q = (x * ceil(2^k / d)) >> k, with d * xmax < 2^k
    localparam int K_DIV99  = 32;
    localparam int K_DIV15  = 23;
    localparam int K_DIV270 = 31;
    localparam int K_DIV25  = 27;
    localparam logic [25:0] RECIP99  = 26'(((64'd1 << K_DIV99) + 64'd98) / 64'd99);
    localparam logic [19:0] RECIP15  = 20'(((64'd1 << K_DIV15) + 64'd14) / 64'd15);
    localparam logic [22:0] RECIP270 = 23'(((64'd1 << K_DIV270) + 64'd269) / 64'd270);
    localparam logic [22:0] RECIP25  = 23'(((64'd1 << K_DIV25) + 64'd24) / 64'd25);

    // input item, first field in the lowest bits
    typedef struct packed {
        logic [2:0]         pad;
        logic [15:0]        trail_right_now;
        logic [15:0]        trail_left_now;
        logic [15:0]        lead_right_now;
        logic [15:0]        lead_left_now;
        logic [13:0]        airspeed;
        logic signed [15:0] angle_of_attack;
        logic [11:0]        mach;
        logic [1:0]         flap_lever;
        logic               on_ground;
    } in_item_t;

    // result item, first field in the lowest bits
    typedef struct packed {
        logic [15:0] trail_right_cmd;
        logic [15:0] trail_left_cmd;
        logic [15:0] lead_right_cmd;
        logic [15:0] lead_left_cmd;
    } out_item_t;

    // pipeline load strobes for the scheduler stages
    typedef struct packed {
        logic load1;
        logic load2;
    } pipe_ctrl_t;

    // scheduled targets with the measured positions of the same frame
    typedef struct packed {
        logic [TARG_W-1:0]            lef_target;
        logic [TARG_W-1:0]            tef_target;
        logic [LANES-1:0][FRAC_W-1:0] now;
    } sched_out_t;

endpackage

// ===== rtl/fsrl_sched.sv =====
// two-stage flap target scheduler: reciprocal multiplies, then law selection
// depends on fsrl_pkg
module fsrl_sched (
    input  logic                 aclk,
    input  fsrl_pkg::pipe_ctrl_t ctrl,
    input  fsrl_pkg::in_item_t   item,
    output fsrl_pkg::sched_out_t sched
);

    // stage 1 combinational terms
    logic signed [15:0] aoa;
    logic               a_pos;
    logic [24:0]        lef_x;
    logic [50:0]        lef_prod;
    logic [18:0]        rise_x;
    logic [38:0]        rise_prod;
    logic [15:0]        fall_d;
    logic [22:0]        fall_x;
    logic [45:0]        fall_prod;
    logic [13:0]        speed_d;
    logic [21:0]        speed_x;
    logic [44:0]        speed_prod;

    // stage 1 registers
    logic        ground_reg, ground_next;
    logic [1:0]  lever_reg, lever_next;
    logic        lef_on_reg, lef_on_next;
    logic        a_pos_reg, a_pos_next;
    logic        rise_reg, rise_next;
    logic        plat_reg, plat_next;
    logic        fall_reg, fall_next;
    logic        mach_aoa_reg, mach_aoa_next;
    logic        mach_clip_reg, mach_clip_next;
    logic        speed_low_reg, speed_low_next;
    logic [18:0] q_lef_reg, q_lef_next;
    logic [14:0] q_rise_reg, q_rise_next;
    logic [14:0] q_fall_reg, q_fall_next;
    logic [17:0] q_speed_reg, q_speed_next;
    logic [fsrl_pkg::LANES-1:0][fsrl_pkg::FRAC_W-1:0] now1_reg, now1_next;

    // stage 2 terms and registers
    logic [fsrl_pkg::TARG_W-1:0] lef_sel;
    logic [fsrl_pkg::TARG_W-1:0] tef_aoa;
    logic [fsrl_pkg::TARG_W-1:0] tef_sched;
    logic [fsrl_pkg::TARG_W-1:0] speed_lim;
    logic [fsrl_pkg::TARG_W-1:0] tef_speed;
    logic [fsrl_pkg::TARG_W-1:0] tef_sel;
    fsrl_pkg::sched_out_t        sched_reg, sched_next;

    // range flags and numerators of the rational laws
    always_comb begin
        aoa     = item.angle_of_attack;
        a_pos   = aoa > 16'sd0;
        lef_x   = {aoa[14:0], 10'd0} + 25'd49;
        rise_x  = {aoa[11:0], 7'd0} + 19'd7;
        fall_d  = 16'(fsrl_pkg::AOA_FALL_END - aoa);
        fall_x  = 23'(fall_d[11:0]) * 23'd2816 + 23'd135;
        speed_d = fsrl_pkg::SPEED_LAW_MAX - item.airspeed;
        speed_x = {speed_d[11:0], 10'd0} + 22'd12;
    end

    // constant divisions as reciprocal multiplies
    assign lef_prod   = 51'(lef_x) * 51'(fsrl_pkg::RECIP99);
    assign rise_prod  = 39'(rise_x) * 39'(fsrl_pkg::RECIP15);
    assign fall_prod  = 46'(fall_x) * 46'(fsrl_pkg::RECIP270);
    assign speed_prod = 45'(speed_x) * 45'(fsrl_pkg::RECIP25);

    always_comb begin
        ground_next    = item.on_ground;
        lever_next     = item.flap_lever;
        lef_on_next    = a_pos && (item.mach <= fsrl_pkg::MACH_LEF_MAX);
        a_pos_next     = a_pos;
        rise_next      = a_pos && (aoa < fsrl_pkg::AOA_RISE_END);
        plat_next      = (aoa >= fsrl_pkg::AOA_RISE_END) && (aoa <= fsrl_pkg::AOA_PLAT_END);
        fall_next      = (aoa > fsrl_pkg::AOA_PLAT_END) && (aoa <= fsrl_pkg::AOA_FALL_END);
        mach_aoa_next  = item.mach <= fsrl_pkg::MACH_AOA_MAX;
        mach_clip_next = item.mach <= fsrl_pkg::MACH_CLIP_MAX;
        speed_low_next = item.airspeed < fsrl_pkg::SPEED_LAW_MAX;
        q_lef_next     = lef_prod[50:32];
        q_rise_next    = rise_prod[37:23];
        q_fall_next    = fall_prod[45:31];
        q_speed_next   = speed_prod[44:27];
        now1_next      = {item.trail_right_now, item.trail_left_now,
                          item.lead_right_now, item.lead_left_now};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            ground_reg    <= ground_next;
            lever_reg     <= lever_next;
            lef_on_reg    <= lef_on_next;
            a_pos_reg     <= a_pos_next;
            rise_reg      <= rise_next;
            plat_reg      <= plat_next;
            fall_reg      <= fall_next;
            mach_aoa_reg  <= mach_aoa_next;
            mach_clip_reg <= mach_clip_next;
            speed_low_reg <= speed_low_next;
            q_lef_reg     <= q_lef_next;
            q_rise_reg    <= q_rise_next;
            q_fall_reg    <= q_fall_next;
            q_speed_reg   <= q_speed_next;
            now1_reg      <= now1_next;
        end
    end

    // leading-edge law
    always_comb begin
        lef_sel = '0;
        if (ground_reg) begin
            if (lever_reg == fsrl_pkg::LEVER_HALF || lever_reg == fsrl_pkg::LEVER_FULL) begin
                lef_sel = fsrl_pkg::LEF_GROUND;
            end
        end else if (lef_on_reg) begin
            lef_sel = (19'(q_lef_reg) > 19'(fsrl_pkg::FULL_FRAC)) ? fsrl_pkg::FULL_FRAC
                                                                  : q_lef_reg[16:0];
        end
    end

    // trailing-edge aoa law with the transonic clip
    always_comb begin
        priority if (rise_reg) begin
            tef_aoa = 17'(q_rise_reg);
        end else if (plat_reg) begin
            tef_aoa = fsrl_pkg::TEF_PLATEAU;
        end else if (fall_reg) begin
            tef_aoa = 17'(q_fall_reg);
        end else begin
            tef_aoa = '0;
        end

        priority if (!a_pos_reg) begin
            tef_sched = '0;
        end else if (mach_aoa_reg) begin
            tef_sched = tef_aoa;
        end else if (mach_clip_reg) begin
            tef_sched = (tef_aoa < fsrl_pkg::TEF_8) ? tef_aoa : fsrl_pkg::TEF_8;
        end else begin
            tef_sched = '0;
        end
    end

    // trailing-edge airspeed law and final selection
    always_comb begin
        speed_lim = (lever_reg == fsrl_pkg::LEVER_HALF) ? fsrl_pkg::TEF_30 : fsrl_pkg::FULL_FRAC;
        tef_speed = (18'(speed_lim) < q_speed_reg) ? speed_lim : q_speed_reg[16:0];
        tef_sel   = '0;
        if (ground_reg) begin
            unique case (lever_reg)
                fsrl_pkg::LEVER_HALF: tef_sel = fsrl_pkg::TEF_30;
                fsrl_pkg::LEVER_FULL: tef_sel = fsrl_pkg::FULL_FRAC;
                default:              tef_sel = '0;
            endcase
        end else begin
            unique case (lever_reg)
                fsrl_pkg::LEVER_AUTO: tef_sel = tef_sched;
                fsrl_pkg::LEVER_HALF,
                fsrl_pkg::LEVER_FULL: tef_sel = speed_low_reg ? tef_speed : tef_sched;
                default:              tef_sel = '0;
            endcase
        end
    end

    always_comb begin
        sched_next.lef_target = lef_sel;
        sched_next.tef_target = tef_sel;
        sched_next.now        = now1_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load2) begin
            sched_reg <= sched_next;
        end
    end

    assign sched = sched_reg;

endmodule

// ===== rtl/fsrl_lane.sv =====
// one flap lane: snap to target within tolerance, else step toward it, saturate
// depends on fsrl_pkg
module fsrl_lane (
    input  logic [fsrl_pkg::TARG_W-1:0] target,
    input  logic [fsrl_pkg::FRAC_W-1:0] now,
    input  logic [fsrl_pkg::FRAC_W-1:0] step,
    input  logic [fsrl_pkg::FRAC_W-1:0] tol,
    output logic [fsrl_pkg::FRAC_W-1:0] cmd
);

    logic signed [17:0] diff;
    logic [16:0]        abs_diff;
    logic               near;
    logic               move_up;
    logic [16:0]        up_sum;
    logic [16:0]        dn_sum;

    // distance to target and both step candidates
    always_comb begin
        diff     = $signed({1'b0, target}) - $signed({2'b00, now});
        abs_diff = diff[17] ? 17'(-diff) : diff[16:0];
        near     = abs_diff < {1'b0, tol};
        move_up  = !diff[17] && (diff != 18'sd0);
        up_sum   = {1'b0, now} + {1'b0, step};
        dn_sum   = {1'b0, now} - {1'b0, step};
    end

    // pick the move and clamp to 0..65535
    always_comb begin
        priority if (near) begin
            cmd = target[16] ? '1 : target[15:0];
        end else if (move_up) begin
            cmd = up_sum[16] ? '1 : up_sum[15:0];
        end else begin
            cmd = dn_sum[16] ? '0 : dn_sum[15:0];
        end
    end

endmodule

// ===== rtl/flap_schedule_rate_limiter.sv =====
// top level: stream ports, config registers, scheduler, four flap lanes, output merge
// depends on fsrl_pkg, fsrl_sched, fsrl_lane
//
//  channel  | ports                               | width | direction
//  ---------+-------------------------------------+-------+----------
//  input    | s_tvalid s_tready s_tdata           | 112   | in
//  result   | m_tvalid m_tready m_tdata           | 64    | out
//  config   | cfg_valid cfg_ready cfg_index cfg_data | 2/16 | in
//
// one frame per cycle sustained while m_tready is high; an input transfer reaches m_tvalid through
// the reciprocal multiply stage, the law select stage, then the lane and output register
// aresetn clears the stage valid bits and loads the config registers with defaults
// a stalled m_tready holds the output register; upstream stages keep filling until full
// cfg_ready is always high; indexes beyond the register list are dropped
module flap_schedule_rate_limiter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // on_ground, flap_lever, mach, angle_of_attack, airspeed, lead_left_now,
    // lead_right_now, trail_left_now, trail_right_now, zero pad
    input  logic [fsrl_pkg::IN_W-1:0]           s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // lead_left_cmd, lead_right_cmd, trail_left_cmd, trail_right_cmd
    output logic [fsrl_pkg::OUT_W-1:0]          m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fsrl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsrl_pkg::FRAC_W-1:0]         cfg_data
);

    logic [fsrl_pkg::FRAC_W-1:0] step_reg, step_next;
    logic [fsrl_pkg::FRAC_W-1:0] tol_reg, tol_next;
    logic                        v1_reg, v1_next;
    logic                        v2_reg, v2_next;
    logic                        v3_reg, v3_next;
    logic                        ready1, ready2, ready3;
    fsrl_pkg::pipe_ctrl_t        ctrl;
    fsrl_pkg::in_item_t          item;
    fsrl_pkg::sched_out_t        sched;
    logic [fsrl_pkg::LANES-1:0][fsrl_pkg::FRAC_W-1:0] lane_cmd;
    fsrl_pkg::out_item_t         out_reg, out_next;

    // config writes
    assign cfg_ready = 1'b1;

    always_comb begin
        step_next = step_reg;
        tol_next  = tol_reg;
        if (cfg_valid) begin
            if (cfg_index == fsrl_pkg::CFG_STEP) begin
                step_next = cfg_data;
            end
            if (cfg_index == fsrl_pkg::CFG_TOL) begin
                tol_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= fsrl_pkg::STEP_RESET;
            tol_reg  <= fsrl_pkg::TOL_RESET;
        end else begin
            step_reg <= step_next;
            tol_reg  <= tol_next;
        end
    end

    // pipeline flow control, each stage moves when the next one frees up
    always_comb begin
        ready3     = !v3_reg || m_tready;
        ready2     = !v2_reg || ready3;
        ready1     = !v1_reg || ready2;
        ctrl.load1 = s_tvalid && ready1;
        ctrl.load2 = v1_reg && ready2;
        v1_next    = ready1 ? s_tvalid : v1_reg;
        v2_next    = ready2 ? v1_reg : v2_reg;
        v3_next    = ready3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign s_tready = ready1;
    assign item     = fsrl_pkg::in_item_t'(s_tdata);

    // target scheduling
    fsrl_sched u_sched (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .item  (item),
        .sched (sched)
    );

    // four flap lanes, leading edge on lanes 0 and 1
    for (genvar i = 0; i < fsrl_pkg::LANES; i++) begin : g_lane
        fsrl_lane u_lane (
            .target (i < 2 ? sched.lef_target : sched.tef_target),
            .now    (sched.now[i]),
            .step   (step_reg),
            .tol    (tol_reg),
            .cmd    (lane_cmd[i])
        );
    end

    // merge lane results into the output register
    always_comb begin
        out_next.lead_left_cmd   = lane_cmd[0];
        out_next.lead_right_cmd  = lane_cmd[1];
        out_next.trail_left_cmd  = lane_cmd[2];
        out_next.trail_right_cmd = lane_cmd[3];
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && ready3) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== verif/tb_top.sv =====
// testbench for flap_schedule_rate_limiter: scoreboard of flap commands against a local predictor
// depends on fsrl_pkg and the rtl top; stream driver and result monitor are clocked always blocks
module tb_top;

    // lever code with no package name, scheduled as "no trailing flap"
    localparam logic [1:0] LEVER_SPARE = 2'd3;

    // register indexes past the end of the register list
    localparam logic [fsrl_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [fsrl_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // target fractions, full travel = 65536
    localparam int TGT_FULL      = 65536;
    localparam int TGT_LEF_GND   = 23831;
    localparam int TGT_TEF_30    = 43691;
    localparam int TGT_TEF_8     = 11651;
    localparam int TGT_TEF_PLAT  = 24030;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [fsrl_pkg::IN_W-1:0]       s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [fsrl_pkg::OUT_W-1:0]      m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [fsrl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fsrl_pkg::FRAC_W-1:0]     cfg_data  = '0;

    // local copy of the config registers
    int step_frac = 655;
    int tol_frac  = 328;

    fsrl_pkg::in_item_t    frames_pending[$];
    fsrl_pkg::out_item_t   cmds_expected[$];
    int unsigned           frames_offered = 0;
    int unsigned           frames_taken   = 0;
    int unsigned           cmds_seen      = 0;
    int unsigned           cmds_taken     = 0;
    int                    send_gap       = 0;
    int                    recv_gap       = 0;
    logic                  idle_on        = 1'b1;
    logic                  mismatch_seen  = 1'b0;
    fsrl_pkg::out_item_t   cmd_got;
    fsrl_pkg::out_item_t   cmd_want;

    flap_schedule_rate_limiter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // rounded division, halves up
    function automatic int div_near(int num, int den);
        return (num + den / 2) / den;
    endfunction

    function automatic int min_of(int a, int b);
        return (a < b) ? a : b;
    endfunction

    // trailing flap from the aoa law
    function automatic int tef_aoa_law(int aoa);
        if (aoa > 0 && aoa < 2816) begin
            return div_near(aoa * 128, 15);
        end
        if (aoa >= 2816 && aoa <= 4096) begin
            return TGT_TEF_PLAT;
        end
        if (aoa > 4096 && aoa <= 6400) begin
            return div_near((6400 - aoa) * 2816, 270);
        end
        return 0;
    endfunction

    // aoa law with the transonic clip
    function automatic int tef_mach_band(int mach, int aoa);
        if (aoa <= 0) begin
            return 0;
        end
        if (mach * 10 < 9216) begin
            return tef_aoa_law(aoa);
        end
        if (mach * 100 < 107520) begin
            return min_of(tef_aoa_law(aoa), TGT_TEF_8);
        end
        return 0;
    endfunction

    // leading and trailing targets of one frame
    function automatic void flap_targets(fsrl_pkg::in_item_t f, output int lef, output int tef);
        int aoa;
        int mach;
        int spd;
        aoa  = int'($signed(f.angle_of_attack));
        mach = int'(f.mach);
        spd  = int'(f.airspeed);
        lef  = 0;
        tef  = 0;
        if (f.on_ground) begin
            if (f.flap_lever == fsrl_pkg::LEVER_HALF) begin
                lef = TGT_LEF_GND;
                tef = TGT_TEF_30;
            end else if (f.flap_lever == fsrl_pkg::LEVER_FULL) begin
                lef = TGT_LEF_GND;
                tef = TGT_FULL;
            end
        end else begin
            if (mach * 100 < 77824 && aoa > 0) begin
                lef = min_of(div_near(aoa * 1024, 99), TGT_FULL);
            end
            if (f.flap_lever == fsrl_pkg::LEVER_AUTO) begin
                tef = tef_mach_band(mach, aoa);
            end else if (f.flap_lever == fsrl_pkg::LEVER_HALF ||
                         f.flap_lever == fsrl_pkg::LEVER_FULL) begin
                if (spd < 4000) begin
                    tef = min_of(div_near((4000 - spd) * 1024, 25),
                                 (f.flap_lever == fsrl_pkg::LEVER_HALF) ? TGT_TEF_30
                                                                        : TGT_FULL);
                end else begin
                    tef = tef_mach_band(mach, aoa);
                end
            end
        end
    endfunction

    // snap within tolerance, else one step toward the target, then saturate
    function automatic logic [15:0] slew_flap(int tgt, int pos);
        int diff;
        int abs_diff;
        int cmd;
        diff     = tgt - pos;
        abs_diff = (diff < 0) ? -diff : diff;
        if (abs_diff < tol_frac) begin
            cmd = tgt;
        end else if (diff > 0) begin
            cmd = pos + step_frac;
        end else begin
            cmd = pos - step_frac;
        end
        if (cmd < 0) cmd = 0;
        if (cmd > 65535) cmd = 65535;
        return cmd[15:0];
    endfunction

    function automatic fsrl_pkg::out_item_t predict_flap_cmds(fsrl_pkg::in_item_t f);
        fsrl_pkg::out_item_t o;
        int lef;
        int tef;
        flap_targets(f, lef, tef);
        o.lead_left_cmd   = slew_flap(lef, int'(f.lead_left_now));
        o.lead_right_cmd  = slew_flap(lef, int'(f.lead_right_now));
        o.trail_left_cmd  = slew_flap(tef, int'(f.trail_left_now));
        o.trail_right_cmd = slew_flap(tef, int'(f.trail_right_now));
        return o;
    endfunction

    function automatic fsrl_pkg::in_item_t frame(int gnd, logic [1:0] lever, int mach, int aoa,
                                                 int spd, int ll, int lr, int tl, int tr);
        fsrl_pkg::in_item_t f;
        f = '0;
        f.on_ground       = gnd[0];
        f.flap_lever      = lever;
        f.mach            = mach[11:0];
        f.angle_of_attack = aoa[15:0];
        f.airspeed        = spd[13:0];
        f.lead_left_now   = ll[15:0];
        f.lead_right_now  = lr[15:0];
        f.trail_left_now  = tl[15:0];
        f.trail_right_now = tr[15:0];
        return f;
    endfunction

    // measured position: anywhere, on target, at the tolerance edge or close by
    function automatic logic [15:0] pick_position(int tgt);
        int k;
        int pos;
        k = int'($urandom_range(0, 9));
        if (k < 4) begin
            pos = int'($urandom_range(0, 65535));
        end else if (k < 6) begin
            pos = tgt;
        end else if (k == 6) begin
            pos = tgt - tol_frac + int'($urandom_range(0, 1));
        end else if (k == 7) begin
            pos = tgt + tol_frac - int'($urandom_range(0, 1));
        end else begin
            pos = tgt + int'($urandom_range(0, 128)) - 64;
        end
        if (pos < 0) pos = 0;
        if (pos > 65535) pos = 65535;
        return pos[15:0];
    endfunction

    function automatic fsrl_pkg::in_item_t random_frame();
        fsrl_pkg::in_item_t f;
        int k;
        int lef;
        int tef;
        f = '0;
        f.on_ground  = ($urandom_range(0, 3) == 0);
        f.flap_lever = 2'($urandom_range(0, 3));
        // mach: around the band edges, 0 to 1200, or anywhere
        k = int'($urandom_range(0, 9));
        if (k < 5) begin
            case ($urandom_range(0, 2))
                0: f.mach = 12'(778 + int'($urandom_range(0, 8)) - 4);
                1: f.mach = 12'(921 + int'($urandom_range(0, 8)) - 4);
                default: f.mach = 12'(1075 + int'($urandom_range(0, 8)) - 4);
            endcase
        end else if (k < 8) begin
            f.mach = 12'($urandom_range(0, 1200));
        end else begin
            f.mach = 12'($urandom_range(0, 4095));
        end
        // aoa: schedule region, breakpoints, or anywhere within +-90 degrees
        k = int'($urandom_range(0, 9));
        if (k < 6) begin
            f.angle_of_attack = 16'($urandom_range(0, 7000));
        end else if (k == 6) begin
            case ($urandom_range(0, 3))
                0: f.angle_of_attack = 16'(2816 + int'($urandom_range(0, 6)) - 3);
                1: f.angle_of_attack = 16'(4096 + int'($urandom_range(0, 6)) - 3);
                2: f.angle_of_attack = 16'(6400 + int'($urandom_range(0, 6)) - 3);
                default: f.angle_of_attack = 16'(int'($urandom_range(0, 6)) - 3);
            endcase
        end else begin
            f.angle_of_attack = 16'(int'($urandom_range(0, 46080)) - 23040);
        end
        // airspeed: slow law, its edge, or anywhere
        k = int'($urandom_range(0, 9));
        if (k < 5) begin
            f.airspeed = 14'($urandom_range(0, 4100));
        end else if (k == 5) begin
            f.airspeed = 14'(4000 + int'($urandom_range(0, 6)) - 3);
        end else begin
            f.airspeed = 14'($urandom_range(0, 16383));
        end
        flap_targets(f, lef, tef);
        f.lead_left_now   = pick_position(lef);
        f.lead_right_now  = pick_position(lef);
        f.trail_left_now  = pick_position(tef);
        f.trail_right_now = pick_position(tef);
        return f;
    endfunction

    function automatic void check_cmd(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s expected %0d actual %0d", field, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    // input driver: one frame per transfer, random gap before each while idling is on
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || frames_taken == frames_offered) begin
            if (s_tvalid) begin
                send_gap = idle_on ? int'($urandom_range(0, 3)) : 0;
            end
            if (send_gap == 0 && frames_pending.size() > 0) begin
                s_tdata  <= frames_pending.pop_front();
                s_tvalid <= 1'b1;
                frames_offered++;
            end else begin
                s_tvalid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end
        end
    end

    // result side ready with a random stall before each transfer while idling is on
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tready && cmds_taken != cmds_seen) begin
                cmds_seen = cmds_taken;
                recv_gap  = idle_on ? int'($urandom_range(0, 3)) : 0;
            end
            if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: predict on input transfer, compare on result transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cmds_expected.push_back(predict_flap_cmds(fsrl_pkg::in_item_t'(s_tdata)));
                frames_taken++;
            end
            if (m_tvalid && m_tready) begin
                cmds_taken++;
                cmd_got = m_tdata;
                if (cmds_expected.size() == 0) begin
                    $error("flap command transfer with none expected: %h", m_tdata);
                    mismatch_seen = 1'b1;
                end else begin
                    cmd_want = cmds_expected.pop_front();
                    check_cmd("lead_left_cmd", cmd_want.lead_left_cmd, cmd_got.lead_left_cmd);
                    check_cmd("lead_right_cmd", cmd_want.lead_right_cmd,
                              cmd_got.lead_right_cmd);
                    check_cmd("trail_left_cmd", cmd_want.trail_left_cmd,
                              cmd_got.trail_left_cmd);
                    check_cmd("trail_right_cmd", cmd_want.trail_right_cmd,
                              cmd_got.trail_right_cmd);
                end
            end
        end
    end

    task automatic write_reg(input logic [fsrl_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == fsrl_pkg::CFG_STEP) begin
            step_frac = val & 16'hFFFF;
        end else if (idx == fsrl_pkg::CFG_TOL) begin
            tol_frac = val & 16'hFFFF;
        end
    endtask

    // wait until every frame is sent and every command is back, plus pipeline slack
    task automatic drain();
        while (frames_pending.size() != 0 || frames_taken != frames_offered ||
               cmds_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            // pick idling on or off at random every 40 frames
            if (k % 40 == 0) begin
                while (frames_pending.size() > 4) @(posedge aclk);
                idle_on = ($urandom_range(0, 3) != 0);
            end
            frames_pending.push_back(random_frame());
        end
    endtask

    // stimulus and config phases
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames at reset config
        frames_pending.push_back(frame(1, fsrl_pkg::LEVER_HALF, 0, 0, 0, 0, 0, 0, 0));
        frames_pending.push_back(frame(1, fsrl_pkg::LEVER_FULL, 4095, 23040, 16383,
                                       23831, 23000, 65535, 65535));
        frames_pending.push_back(frame(1, fsrl_pkg::LEVER_AUTO, 500, 3000, 2000,
                                       1000, 65535, 30000, 0));
        frames_pending.push_back(frame(1, LEVER_SPARE, 500, 3000, 2000, 1000, 2000, 3000, 4000));
        frames_pending.push_back(frame(0, LEVER_SPARE, 500, 3000, 2000, 0, 65535, 0, 65535));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 0, -23040, 0,
                                       65535, 100, 65535, 200));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 778, 23040, 8000,
                                       65535, 65400, 0, 0));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 779, 2816, 8000,
                                       30000, 0, 24030, 24000));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 921, 4096, 8000,
                                       0, 0, 24029, 65535));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 922, 3000, 8000,
                                       0, 0, 11651, 11000));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 1075, 2000, 8000,
                                       5000, 0, 11700, 0));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 1076, 2000, 8000,
                                       5000, 0, 300, 400));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 500, 6400, 8000,
                                       65535, 0, 0, 65535));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 500, 4097, 8000,
                                       0, 65535, 24000, 23800));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 500, 1, 8000, 10, 0, 9, 0));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 4095, 0, 8000,
                                       100, 65535, 100, 65535));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_HALF, 500, 2000, 0,
                                       0, 65535, 43691, 43500));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_FULL, 500, 2000, 0,
                                       0, 65535, 65535, 65300));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_HALF, 500, 2000, 3999,
                                       20000, 21000, 0, 41));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_FULL, 500, 5000, 4000,
                                       0, 65535, 0, 65535));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_HALF, 600, 2815, 16383, 1, 2, 3, 4));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_FULL, 900, -1, 3000, 0, 0, 0, 0));
        send_random(313);
        drain();

        // frozen flaps, no snap window
        write_reg(fsrl_pkg::CFG_STEP, 0);
        write_reg(fsrl_pkg::CFG_TOL, 0);
        frames_pending.push_back(frame(1, fsrl_pkg::LEVER_HALF, 0, 0, 0,
                                       23831, 23831, 43691, 43691));
        frames_pending.push_back(frame(0, fsrl_pkg::LEVER_AUTO, 500, 0, 8000, 0, 0, 0, 0));
        send_random(313);
        drain();

        // widest step and tolerance
        write_reg(fsrl_pkg::CFG_STEP, 65535);
        write_reg(fsrl_pkg::CFG_TOL, 65535);
        send_random(313);
        drain();

        // writes to unused indexes must change nothing
        write_reg(CFG_SPARE_A, int'($urandom_range(0, 65535)));
        write_reg(CFG_SPARE_B, int'($urandom_range(0, 65535)));
        write_reg(fsrl_pkg::CFG_STEP, int'($urandom_range(0, 65535)));
        write_reg(fsrl_pkg::CFG_TOL, int'($urandom_range(0, 4095)));
        send_random(313);
        drain();

        // finest step
        write_reg(fsrl_pkg::CFG_STEP, 1);
        write_reg(fsrl_pkg::CFG_TOL, 1);
        send_random(313);
        drain();

        // back to reset values, with a full stop halfway through
        write_reg(fsrl_pkg::CFG_STEP, 655);
        write_reg(fsrl_pkg::CFG_TOL, 328);
        send_random(150);
        drain();
        send_random(163);
        drain();

        if (!mismatch_seen) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
